// File: design/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/pew_pkg.sv
// shared types and constants of the prewitt edge magnitude unit
`timescale 1ns / 1ps
`default_nettype none
package pew_pkg;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int PIX_BITS      = 8;
   localparam int PX_BITS       = 24;
   localparam int CFG_W_BITS    = 12;
   localparam int CFG_H_BITS    = 16;
   localparam int CSR_BITS      = 16;
   localparam int COL_OUT_BITS  = 11;
   localparam int ROW_BITS      = 16;
   localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 12'd2048;
   localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 16'd2048;

   // register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_ROOT,
      ST_EMIT
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic square;
      logic root_load;
      logic root_step;
      logic emit;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic root_last;
      logic pend_none;
      logic pend_one;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: design/prewitt_edge_magnitude_rgb_unit.sv
// top level of the prewitt edge magnitude unit for bgr pixel streams
`timescale 1ns / 1ps
`default_nettype none
// Takes bgr pixels in raster order and returns, per channel, the Prewitt
// gradient magnitude floor(sqrt(gx^2+gy^2)) saturated to 255, zero on the
// frame border, each result tagged with its column and row. One pixel item
// gives zero to three result items, the last one flagged by last_of_run.
// The first result of an item is shown once the line-store read, the
// squaring stage, the root load and eight steps of the bit-serial square
// root are done and the result register is loaded. Further results follow
// one per cycle while the receiver takes them. The input is ready again in
// the cycle after the last result is loaded, or after the emit state for an
// item without results, so one item is handled at a time. The last result
// may still wait in the output register while the next item is taken.
// Line stores are not cleared; the user must write image_width and
// image_height only while the unit is idle, the unit does not enforce this.
module prewitt_edge_magnitude_rgb_unit
   import pew_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [PIX_BITS-1:0]     req_blue_in,
   input  wire logic [PIX_BITS-1:0]     req_green_in,
   input  wire logic [PIX_BITS-1:0]     req_red_in,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [PIX_BITS-1:0]          rsp_blue_edge,
   output logic [PIX_BITS-1:0]          rsp_green_edge,
   output logic [PIX_BITS-1:0]          rsp_red_edge,
   output logic [COL_OUT_BITS-1:0]      rsp_out_column,
   output logic [ROW_BITS-1:0]          rsp_out_row,
   output logic                         rsp_last_of_run,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [0:0]              csr_index,
   input  wire logic [CSR_BITS-1:0]     csr_data
);

   cmd_type    cmd;
   status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // controller
   pew_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   pew_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_blue_in     (req_blue_in),
      .req_green_in    (req_green_in),
      .req_red_in      (req_red_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_blue_edge   (rsp_blue_edge),
      .rsp_green_edge  (rsp_green_edge),
      .rsp_red_edge    (rsp_red_edge),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_row     (rsp_out_row),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

endmodule
`default_nettype wire

// File: design/pew_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module pew_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: design/pew_ctrl.sv
// controller state machine of the prewitt edge magnitude unit
`timescale 1ns / 1ps
`default_nettype none
module pew_ctrl
   import pew_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.pend_none || (status.out_free && status.pend_one)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_FETCH: cmd.square    = 1'b1;
         ST_LOAD:  cmd.root_load = 1'b1;
         ST_ROOT:  cmd.root_step = 1'b1;
         ST_EMIT:  cmd.emit      = status.out_free && !status.pend_none;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// File: design/pew_datapath.sv
// datapath: position counters, line stores, window, gradients and square root
`timescale 1ns / 1ps
`default_nettype none
module pew_datapath
   import pew_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output status_type                   status,
   input  wire logic [PIX_BITS-1:0]     req_blue_in,
   input  wire logic [PIX_BITS-1:0]     req_green_in,
   input  wire logic [PIX_BITS-1:0]     req_red_in,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [PIX_BITS-1:0]          rsp_blue_edge,
   output logic [PIX_BITS-1:0]          rsp_green_edge,
   output logic [PIX_BITS-1:0]          rsp_red_edge,
   output logic [COL_OUT_BITS-1:0]      rsp_out_column,
   output logic [ROW_BITS-1:0]          rsp_out_row,
   output logic                         rsp_last_of_run,
   input  wire logic                    csr_valid,
   input  wire logic [0:0]              csr_index,
   input  wire logic [CSR_BITS-1:0]     csr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WWN = $clog2(MAX_WIDTH + 1);
   localparam int WEW = (WWN > CFG_W_BITS) ? WWN : CFG_W_BITS;

   // configuration
   logic [CFG_W_BITS-1:0] width_ff;
   logic [CFG_H_BITS-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_IMAGE_WIDTH)  width_ff  <= csr_data[CFG_W_BITS-1:0];
         if (csr_index == CSR_IMAGE_HEIGHT) height_ff <= csr_data[CFG_H_BITS-1:0];
      end
   end

   // effective frame size and current position
   logic [WEW-1:0]      w_cfg, w_eff;
   logic [ROW_BITS-1:0] h_eff;
   logic [CW-1:0]       col_ff, col_cur, col_in;
   logic [ROW_BITS-1:0] row_ff, row_cur, row_in;
   logic [WEW-1:0]      col_inc;
   logic [ROW_BITS:0]   row_inc;
   logic [3:0]          flags;

   assign w_cfg   = WEW'(width_ff);
   assign w_eff   = (w_cfg < WEW'(3)) ? WEW'(3) :
                    (w_cfg > WEW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : w_cfg;
   assign h_eff   = (height_ff < ROW_BITS'(3)) ? ROW_BITS'(3) : height_ff;
   assign col_cur = (WEW'(col_ff) >= w_eff) ? '0 : col_ff;
   assign row_cur = (row_ff >= h_eff) ? '0 : row_ff;
   assign col_inc = WEW'(col_cur) + WEW'(1);
   assign row_inc = {1'b0, row_cur} + (ROW_BITS+1)'(1);

   // next raster position with wrap at row and frame end
   always_comb begin
      col_in = col_inc[CW-1:0];
      row_in = row_cur;
      if (col_inc >= w_eff) begin
         col_in = '0;
         row_in = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_BITS-1:0];
      end
   end

   // pending results: left border, interior, right border, top or bottom row
   always_comb begin
      flags[0] = (row_cur >= ROW_BITS'(2)) && (col_cur == '0);
      flags[1] = (row_cur >= ROW_BITS'(2)) && (col_cur >= CW'(2));
      flags[2] = (row_cur >= ROW_BITS'(2)) && (WEW'(col_cur) == w_eff - WEW'(1));
      flags[3] = (row_cur == h_eff - ROW_BITS'(1)) || (row_cur == '0);
   end

   logic [CW-1:0]       cpos_ff, wlast_ff;
   logic [ROW_BITS-1:0] rpos_ff;
   logic [PX_BITS-1:0]  px_ff;
   logic [3:0]          pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
      end else if (cmd.capture) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= flags;
      end else if (cmd.emit) begin
         pend_ff <= pend_ff & (pend_ff - 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cpos_ff  <= col_cur;
         rpos_ff  <= row_cur;
         wlast_ff <= CW'(w_eff - WEW'(1));
         px_ff    <= {req_red_in, req_green_in, req_blue_in};
      end
   end

   // line stores: older holds row r-2, newer row r-1
   logic [PX_BITS-1:0] top_px, mid_px;

   pew_ram #(.WIDTH(PX_BITS), .DEPTH(MAX_WIDTH)) u_older (
      .clock   (clock),
      .wr_en   (cmd.square),
      .wr_addr (cpos_ff),
      .wr_data (mid_px),
      .rd_en   (cmd.capture),
      .rd_addr (col_cur),
      .rd_data (top_px)
   );

   pew_ram #(.WIDTH(PX_BITS), .DEPTH(MAX_WIDTH)) u_newer (
      .clock   (clock),
      .wr_en   (cmd.square),
      .wr_addr (cpos_ff),
      .wr_data (px_ff),
      .rd_en   (cmd.capture),
      .rd_addr (col_cur),
      .rd_data (mid_px)
   );

   // window of the two previous columns, top to bottom
   logic [PX_BITS-1:0] win_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (cmd.square) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_px;
         win_ff[4] <= mid_px;
         win_ff[5] <= px_ff;
      end
   end

   // vertical and horizontal prewitt sums and their squares per channel
   logic signed [10:0] gv [3];
   logic signed [10:0] gh [3];
   logic signed [21:0] pv [3];
   logic signed [21:0] ph [3];
   logic [19:0]        sqv_ff [3];
   logic [19:0]        sqh_ff [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         gv[ch] = ($signed({3'b0, win_ff[2][8*ch +: 8]}) + $signed({3'b0, win_ff[5][8*ch +: 8]})
                 + $signed({3'b0, px_ff[8*ch +: 8]}))
                - ($signed({3'b0, win_ff[0][8*ch +: 8]}) + $signed({3'b0, win_ff[3][8*ch +: 8]})
                 + $signed({3'b0, top_px[8*ch +: 8]}));
         gh[ch] = ($signed({3'b0, win_ff[0][8*ch +: 8]}) + $signed({3'b0, win_ff[1][8*ch +: 8]})
                 + $signed({3'b0, win_ff[2][8*ch +: 8]}))
                - ($signed({3'b0, top_px[8*ch +: 8]}) + $signed({3'b0, mid_px[8*ch +: 8]})
                 + $signed({3'b0, px_ff[8*ch +: 8]}));
         pv[ch] = gv[ch] * gv[ch];
         ph[ch] = gh[ch] * gh[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         for (int ch = 0; ch < 3; ch++) begin
            sqv_ff[ch] <= pv[ch][19:0];
            sqh_ff[ch] <= ph[ch][19:0];
         end
      end
   end

   // bit-serial square root, one result bit per cycle, msb first
   logic [20:0]         sum [3];
   logic [15:0]         val_ff [3];
   logic [2:0]          sat_ff;
   logic [PIX_BITS-1:0] root_ff [3];
   logic [PIX_BITS-1:0] trial [3];
   logic [15:0]         tsq [3];
   logic [2:0]          bit_ff;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch]   = {1'b0, sqv_ff[ch]} + {1'b0, sqh_ff[ch]};
         trial[ch] = root_ff[ch] | (PIX_BITS'(1) << bit_ff);
         tsq[ch]   = trial[ch] * trial[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.root_load) begin
         bit_ff <= 3'd7;
         for (int ch = 0; ch < 3; ch++) begin
            val_ff[ch]  <= sum[ch][15:0];
            sat_ff[ch]  <= |sum[ch][20:16];
            root_ff[ch] <= '0;
         end
      end else if (cmd.root_step) begin
         bit_ff <= bit_ff - 3'd1;
         for (int ch = 0; ch < 3; ch++) begin
            if (tsq[ch] <= val_ff[ch]) root_ff[ch] <= trial[ch];
         end
      end
   end

   // result register: next pending result in order
   logic                    out_valid_ff;
   logic [PX_BITS-1:0]      out_px_ff;
   logic [COL_OUT_BITS-1:0] out_col_ff;
   logic [ROW_BITS-1:0]     out_row_ff;
   logic                    out_last_ff;
   logic [PX_BITS-1:0]      mag;
   logic [PX_BITS-1:0]      sel_px;
   logic [CW-1:0]           sel_col;
   logic [ROW_BITS-1:0]     sel_row;
   logic [3:0]              rest;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         mag[8*ch +: 8] = sat_ff[ch] ? 8'd255 : root_ff[ch];
      end
      sel_px  = '0;
      sel_col = cpos_ff;
      sel_row = rpos_ff - ROW_BITS'(1);
      priority if (pend_ff[0]) begin
         sel_col = '0;
      end else if (pend_ff[1]) begin
         sel_px  = mag;
         sel_col = cpos_ff - CW'(1);
      end else if (pend_ff[2]) begin
         sel_col = wlast_ff;
      end else begin
         sel_row = rpos_ff;
      end
      rest = pend_ff & (pend_ff - 4'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_px_ff   <= sel_px;
         out_col_ff  <= COL_OUT_BITS'(sel_col);
         out_row_ff  <= sel_row;
         out_last_ff <= (rest == 4'd0);
      end
   end

   assign status.root_last = (bit_ff == 3'd0);
   assign status.pend_none = (pend_ff == 4'd0);
   assign status.pend_one  = (rest == 4'd0) && (pend_ff != 4'd0);
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_blue_edge   = out_px_ff[7:0];
   assign rsp_green_edge  = out_px_ff[15:8];
   assign rsp_red_edge    = out_px_ff[23:16];
   assign rsp_out_column  = out_col_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule
`default_nettype wire

// File: design/pew_checker.sv
// port-level checker of the prewitt edge magnitude unit and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pew_checker
   import pew_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [PIX_BITS-1:0]     rsp_blue_edge,
   input wire logic [PIX_BITS-1:0]     rsp_green_edge,
   input wire logic [PIX_BITS-1:0]     rsp_red_edge,
   input wire logic [COL_OUT_BITS-1:0] rsp_out_column,
   input wire logic [ROW_BITS-1:0]     rsp_out_row,
   input wire logic                    rsp_last_of_run
);

   // whole result payload
   logic [3*PIX_BITS+COL_OUT_BITS+ROW_BITS:0] rsp_payload;

   assign rsp_payload = {rsp_blue_edge, rsp_green_edge, rsp_red_edge,
                         rsp_out_column, rsp_out_row, rsp_last_of_run};

   // no result item straight out of reset
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

   // one item at a time: busy right after an item is taken
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // while a result other than the last is shown, more of the same item follow
   `ASSERT_NOW(a_busy_mid_run, clock, reset, rsp_valid && !rsp_last_of_run, !req_ready)

   // a stalled result keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind prewitt_edge_magnitude_rgb_unit pew_checker u_checker (.*);
`default_nettype wire

// File: sim/prewitt_edge_magnitude_rgb_unit_tb.sv
// testbench of the prewitt edge magnitude unit: frames of random and patterned pixels checked against a predictor
`timescale 1ns / 1ps

module prewitt_edge_magnitude_rgb_unit_tb;
   import pew_pkg::*;

   // one expected or observed result item
   typedef struct {
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [10:0] column;
      logic [15:0] row;
      logic        last;
   } edge_item_type;

   // predicts edge results from accepted pixels and compares returned items
   class edge_scoreboard;
      logic [23:0] older_row[MAX_WIDTH_DEF];
      logic [23:0] newer_row[MAX_WIDTH_DEF];
      logic [23:0] window[6];
      int unsigned col_pos, row_pos;
      int unsigned width_reg, height_reg;
      edge_item_type awaited[$];
      int          errors;
      int          results_seen;
      int          pixels_seen;

      function void clear_state();
         foreach (window[i]) window[i] = '0;
         col_pos    = 0;
         row_pos    = 0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] data);
         if (idx == CSR_IMAGE_WIDTH) width_reg = data[11:0];
         else height_reg = data;
      endfunction

      function int unsigned root_sat(int unsigned v);
         int unsigned r, t;
         r = 0;
         if (v >= 65536) return 255;
         for (int b = 7; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      // window p[col*3+row], col 0 left, row 0 top
      function logic [7:0] grad(logic [23:0] p[9], int sh);
         int v, h;
         int c[9];
         for (int i = 0; i < 9; i++) c[i] = (p[i] >> sh) & 8'hFF;
         v = (c[2] + c[5] + c[8]) - (c[0] + c[3] + c[6]);
         h = (c[0] + c[1] + c[2]) - (c[6] + c[7] + c[8]);
         return 8'(root_sat(v * v + h * h));
      endfunction

      function void push_result(logic [23:0] px, int unsigned c, int unsigned r);
         edge_item_type e;
         e.blue   = px[7:0];
         e.green  = px[15:8];
         e.red    = px[23:16];
         e.column = c[10:0];
         e.row    = r[15:0];
         e.last   = 1'b0;
         awaited.push_back(e);
      endfunction

      function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] rd);
         int unsigned w, h, c, r, n0;
         logic [23:0] px, top, mid;
         logic [23:0] p[9];
         w = width_reg;
         h = height_reg;
         if (w < 3) w = 3;
         if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
         if (h < 3) h = 3;
         if (col_pos >= w) col_pos = 0;
         if (row_pos >= h) row_pos = 0;
         c   = col_pos;
         r   = row_pos;
         n0  = awaited.size();
         px  = {rd, g, b};
         top = older_row[c];
         mid = newer_row[c];
         pixels_seen++;
         if (r >= 2) begin
            if (c == 0) begin
               push_result('0, 0, r - 1);
            end else if (c >= 2) begin
               for (int i = 0; i < 6; i++) p[i] = window[i];
               p[6] = top;
               p[7] = mid;
               p[8] = px;
               push_result({grad(p, 16), grad(p, 8), grad(p, 0)}, c - 1, r - 1);
            end
            if (c == w - 1) push_result('0, w - 1, r - 1);
         end
         if (r == h - 1 || r == 0) push_result('0, c, r);
         // shift window and line stores
         window[0] = window[3];
         window[1] = window[4];
         window[2] = window[5];
         window[3] = top;
         window[4] = mid;
         window[5] = px;
         older_row[c] = mid;
         newer_row[c] = px;
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         col_pos = c;
         row_pos = r;
         if (awaited.size() > n0) awaited[awaited.size() - 1].last = 1'b1;
      endfunction

      function void check_result(edge_item_type got);
         edge_item_type e;
         results_seen++;
         if (awaited.size() == 0) begin
            $display("%t unexpected result col %0d row %0d", $time, got.column, got.row);
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (got.blue !== e.blue)
            $display("%t blue_edge exp %0d got %0d", $time, e.blue, got.blue);
         if (got.green !== e.green)
            $display("%t green_edge exp %0d got %0d", $time, e.green, got.green);
         if (got.red !== e.red)
            $display("%t red_edge exp %0d got %0d", $time, e.red, got.red);
         if (got.column !== e.column)
            $display("%t out_column exp %0d got %0d", $time, e.column, got.column);
         if (got.row !== e.row)
            $display("%t out_row exp %0d got %0d", $time, e.row, got.row);
         if (got.last !== e.last)
            $display("%t last_of_run exp %0d got %0d", $time, e.last, got.last);
         if (got.blue !== e.blue || got.green !== e.green || got.red !== e.red ||
             got.column !== e.column || got.row !== e.row || got.last !== e.last)
            errors++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_blue_in, req_green_in, req_red_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_blue_edge, rsp_green_edge, rsp_red_edge;
   logic [10:0] rsp_out_column;
   logic [15:0] rsp_out_row;
   logic        rsp_last_of_run;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [15:0] csr_data;

   edge_scoreboard edges = new();
   int  send_idle;
   int  recv_idle;
   bit  long_hold;

   prewitt_edge_magnitude_rgb_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_blue_in(req_blue_in), .req_green_in(req_green_in), .req_red_in(req_red_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_blue_edge(rsp_blue_edge), .rsp_green_edge(rsp_green_edge),
      .rsp_red_edge(rsp_red_edge), .rsp_out_column(rsp_out_column),
      .rsp_out_row(rsp_out_row), .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // overall time limit
   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   // result receiver with random stalls and one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // compare every accepted result
   always @(posedge clock) begin
      edge_item_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.blue   = rsp_blue_edge;
         got.green  = rsp_green_edge;
         got.red    = rsp_red_edge;
         got.column = rsp_out_column;
         got.row    = rsp_out_row;
         got.last   = rsp_last_of_run;
         edges.check_result(got);
      end
   end

   task automatic write_csr(csr_index_type idx, logic [15:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      edges.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // pixel source: 0 random, 1 bytes at the extremes, 2 alternating red and cyan
   task automatic send_frame(int count, int mode);
      logic [7:0] b, g, r;
      for (int i = 0; i < count; i++) begin
         while ($urandom_range(99) < send_idle) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
         case (mode)
            0: begin
               b = $urandom; g = $urandom; r = $urandom;
            end
            1: begin
               b = $urandom_range(1) ? 8'hFF : 8'h00;
               g = $urandom_range(1) ? 8'hFF : 8'h00;
               r = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            default: begin
               b = (i % 2) ? 8'hFF : 8'h00;
               g = b;
               r = ~b;
            end
         endcase
         req_valid    = 1'b1;
         req_blue_in  = b;
         req_green_in = g;
         req_red_in   = r;
         do @(posedge clock); while (!req_ready);
         edges.note_pixel(b, g, r);
         @(negedge clock);
      end
      req_valid = 1'b0;
   endtask

   // wait until every expected result is back, then let a possible silent item finish
   task automatic drain();
      while (edges.awaited.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // phase table: width data, height data, pixel count, pixel mode
   // each phase starts at row zero so no line entry is read before it is written
   int ph_w[9]  = '{3, 4, 5, 0, 7, 3, 12, 16'hFFFF, 9};
   int ph_h[9]  = '{3, 3, 4, 0, 6, 16'hFFFF, 4, 3, 7};
   int ph_n[9]  = '{9, 12, 20, 9, 42, 12, 48, 35, 63};
   int ph_m[9]  = '{1, 2, 0, 0, 0, 0, 1, 0, 0};

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_blue_in  = '0;
      req_green_in = '0;
      req_red_in   = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_IMAGE_WIDTH;
      csr_data     = '0;
      long_hold    = 1'b0;
      send_idle    = 38;
      recv_idle    = 50;
      edges.clear_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < 9; p++) begin
         send_idle = (p < 3) ? 38 : (p < 6) ? 50 : 0;
         recv_idle = (p < 3) ? 50 : (p < 6) ? 38 : 0;
         write_csr(CSR_IMAGE_WIDTH, 16'(ph_w[p]));
         write_csr(CSR_IMAGE_HEIGHT, 16'(ph_h[p]));
         if (p == 2) long_hold = 1'b1;
         send_frame(ph_n[p], ph_m[p]);
         drain();
      end

      $display("covered %0d pixels and %0d results over widths 3..2048, heights 3..65535",
               edges.pixels_seen, edges.results_seen);
      $display("with random stalls on both sides and one long output hold-off");
      if (edges.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/pew_pkg.sv
design/pew_ram.sv
design/pew_ctrl.sv
design/pew_datapath.sv
design/prewitt_edge_magnitude_rgb_unit.sv
design/pew_checker.sv
sim/prewitt_edge_magnitude_rgb_unit_tb.sv
